// File: rtl/core/assert_macros.svh
// Assertion helpers for the checker file m2pow_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/m2pow_pkg.sv
`default_nettype none
package m2pow_pkg;

  localparam int EXP_BITS      = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ELEM_W        = 32;

  typedef logic signed [ELEM_W-1:0] elem_t;

  localparam elem_t ELEM_MAX = 32'sh7FFF_FFFF;
  localparam elem_t ELEM_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [ELEM_W-1:0]   a00;
    logic signed [ELEM_W-1:0]   a01;
    logic signed [ELEM_W-1:0]   a10;
    logic signed [ELEM_W-1:0]   a11;
    logic signed [EXP_BITS-1:0] exponent;
  } req_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] r00;
    logic signed [ELEM_W-1:0] r01;
    logic signed [ELEM_W-1:0] r10;
    logic signed [ELEM_W-1:0] r11;
    logic                     singular;
    logic                     saturated;
  } rsp_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DET,
    ST_CHK,
    ST_DIV,
    ST_STEP,
    ST_MUL,
    ST_COPY,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// File: rtl/core/m2pow_div.sv
`default_nettype none
module m2pow_div #(
  parameter int FRAC_BITS = m2pow_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [32:0]    adj,
  input  logic [63:0]           dmag,
  input  logic                  dneg,
  output m2pow_pkg::div_stat_t  stat,
  output m2pow_pkg::elem_t      quo
);

  localparam int NUM_W = 32 + 2 * FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [33:0] CAP = 34'h1_0000_0000;

  logic [NUM_W-1:0] num;
  logic [63:0]      rem;
  logic [32:0]      q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             neg;
  logic             done;

  logic [64:0] rs;
  logic        ge;
  logic [64:0] rn;
  logic [33:0] qs;
  logic [32:0] qn;
  logic [32:0] amag;

  always_comb begin
    rs   = {rem, num[NUM_W-1]};
    ge   = rs >= {1'b0, dmag};
    rn   = ge ? (rs - {1'b0, dmag}) : rs;
    qs   = {q, ge};
    qn   = (qs > CAP) ? CAP[32:0] : qs[32:0];
    amag = adj[32] ? (-adj) : adj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        num  <= {amag[31:0], {(2 * FRAC_BITS){1'b0}}};
        rem  <= '0;
        q    <= '0;
        cnt  <= CNT_W'(NUM_W);
        busy <= 1'b1;
        neg  <= adj[32] ^ dneg;
      end else if (busy) begin
        num <= {num[NUM_W-2:0], 1'b0};
        rem <= rn[63:0];
        q   <= qn;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    stat.done = done;
    if (neg) begin
      stat.sat = q > 33'h0_8000_0000;
      quo      = stat.sat ? m2pow_pkg::ELEM_MIN : -$signed(q[31:0]);
    end else begin
      stat.sat = q > 33'h0_7FFF_FFFF;
      quo      = stat.sat ? m2pow_pkg::ELEM_MAX : $signed(q[31:0]);
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/matrix2x2_signed_power_core.sv
`default_nettype none
// Raises a 2x2 matrix of signed fixed-point elements (FRAC_BITS fraction bits) to a signed
// integer power. One 32x32 multiplier is reused for every product, and a matrix product
// is built one element at a time. Exponents 0 and 1 skip the products and return the
// identity or the input matrix. A positive exponent e is worked by square-and-multiply
// over the bits of e-1. A negative exponent first computes the determinant and the
// singular check, then the inverse element by element in the bit-serial divider. One
// request is worked on at a time; req_stall stays high until the result is loaded into
// the output register, which holds it while rsp_stall is high.
module matrix2x2_signed_power_core #(
  parameter int FRAC_BITS = m2pow_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  m2pow_pkg::req_t    req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output m2pow_pkg::rsp_t    rsp,
  input  logic               cfg_wen,
  input  logic [30:0]        cfg_wdata
);

  localparam int E = m2pow_pkg::EXP_BITS;

  m2pow_pkg::state_t state, state_next;

  logic [30:0]         thr;
  m2pow_pkg::elem_t    res [4];
  m2pow_pkg::elem_t    tmp [4];
  m2pow_pkg::elem_t    z   [4];
  logic [E-1:0]        n;
  logic                odd_done;
  logic                sq;
  logic                inv;
  logic [1:0]          elem;
  logic [1:0]          phase;
  logic signed [63:0]  acc;
  logic signed [63:0]  prod;
  logic signed [64:0]  det;
  logic                sat;
  logic                sing;
  logic                div_started;

  logic                accept;
  logic                load_rsp;
  logic                div_start;
  logic signed [E:0]   ex_ext;
  logic [E:0]          mag;
  logic                t;
  logic [1:0]          xi;
  logic [1:0]          yi;
  m2pow_pkg::elem_t    mx;
  m2pow_pkg::elem_t    my;
  logic signed [64:0]  sum;
  logic signed [64:0]  sh;
  logic                ovp;
  logic                ovn;
  m2pow_pkg::elem_t    clamped;
  logic [63:0]         dmag;
  logic [63:0]         thr_sh;
  logic                is_sing;
  logic signed [32:0]  adj;
  m2pow_pkg::div_stat_t div_stat;
  m2pow_pkg::elem_t    div_quo;
  m2pow_pkg::elem_t    ident;

  always_comb begin
    ex_ext  = {req.exponent[E-1], req.exponent};
    mag     = req.exponent[E-1] ? (-ex_ext) : ex_ext;
    ident   = m2pow_pkg::elem_t'(33'sd1 <<< FRAC_BITS);
    t       = phase[0];
    xi      = {elem[1], t};
    yi      = {t, elem[0]};
    if (state == m2pow_pkg::ST_DET) begin
      mx = t ? res[1] : res[0];
      my = t ? res[2] : res[3];
    end else begin
      mx = sq ? tmp[xi] : res[xi];
      my = tmp[yi];
    end
    if (state == m2pow_pkg::ST_DET) begin
      sum = {acc[63], acc} - {prod[63], prod};
    end else begin
      sum = {acc[63], acc} + {prod[63], prod};
    end
    sh      = sum >>> FRAC_BITS;
    ovp     = !sh[64] && (|sh[63:31]);
    ovn     = sh[64] && !(&sh[63:31]);
    clamped = ovp ? m2pow_pkg::ELEM_MAX : (ovn ? m2pow_pkg::ELEM_MIN : sh[31:0]);
    dmag    = det[64] ? 64'(-det) : det[63:0];
    thr_sh  = 64'(thr) << FRAC_BITS;
    is_sing = dmag <= thr_sh;
    case (elem)
      2'd0:    adj = {res[3][31], res[3]};
      2'd1:    adj = -{res[1][31], res[1]};
      2'd2:    adj = -{res[2][31], res[2]};
      default: adj = {res[0][31], res[0]};
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      m2pow_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req.exponent == E'(0) || req.exponent == E'(1)) begin
            state_next = m2pow_pkg::ST_DONE;
          end else if (req.exponent[E-1]) begin
            state_next = m2pow_pkg::ST_DET;
          end else begin
            state_next = m2pow_pkg::ST_STEP;
          end
        end
      end
      m2pow_pkg::ST_DET: begin
        if (phase == 2'd2) begin
          state_next = m2pow_pkg::ST_CHK;
        end
      end
      m2pow_pkg::ST_CHK: begin
        state_next = is_sing ? m2pow_pkg::ST_DONE : m2pow_pkg::ST_DIV;
      end
      m2pow_pkg::ST_DIV: begin
        if (div_stat.done && elem == 2'd3) begin
          state_next = m2pow_pkg::ST_COPY;
        end
      end
      m2pow_pkg::ST_STEP: begin
        if (n == E'(0)) begin
          state_next = m2pow_pkg::ST_DONE;
        end else if (n[0] && !odd_done) begin
          state_next = m2pow_pkg::ST_MUL;
        end else if (n == E'(1)) begin
          state_next = m2pow_pkg::ST_DONE;
        end else begin
          state_next = m2pow_pkg::ST_MUL;
        end
      end
      m2pow_pkg::ST_MUL: begin
        if (phase == 2'd2 && elem == 2'd3) begin
          state_next = m2pow_pkg::ST_COPY;
        end
      end
      m2pow_pkg::ST_COPY: begin
        state_next = m2pow_pkg::ST_STEP;
      end
      m2pow_pkg::ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = m2pow_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = m2pow_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_stall = state != m2pow_pkg::ST_IDLE;
    accept    = (state == m2pow_pkg::ST_IDLE) && req_valid;
    div_start = (state == m2pow_pkg::ST_DIV) && !div_started;
    load_rsp  = (state == m2pow_pkg::ST_DONE) && (!rsp_valid || !rsp_stall);
  end

  m2pow_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .adj  (adj),
    .dmag (dmag),
    .dneg (det[64]),
    .stat (div_stat),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= m2pow_pkg::ST_IDLE;
      thr         <= '0;
      rsp_valid   <= 1'b0;
      div_started <= 1'b0;
      elem        <= '0;
      phase       <= '0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        thr <= cfg_wdata;
      end
      rsp_valid <= load_rsp || (rsp_valid && rsp_stall);
      if (div_start) begin
        div_started <= 1'b1;
      end
      if (accept) begin
        elem  <= '0;
        phase <= '0;
      end
      if (state == m2pow_pkg::ST_DET || state == m2pow_pkg::ST_MUL) begin
        if (phase == 2'd2) begin
          phase <= '0;
          if (state == m2pow_pkg::ST_MUL) begin
            elem <= elem + 2'd1;
          end
        end else begin
          phase <= phase + 2'd1;
        end
      end
      if (state == m2pow_pkg::ST_DIV && div_stat.done) begin
        div_started <= 1'b0;
        elem        <= elem + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mx * my;
    if (accept) begin
      res[0]   <= (req.exponent == E'(0)) ? ident : req.a00;
      res[1]   <= (req.exponent == E'(0)) ? '0 : req.a01;
      res[2]   <= (req.exponent == E'(0)) ? '0 : req.a10;
      res[3]   <= (req.exponent == E'(0)) ? ident : req.a11;
      tmp[0]   <= req.a00;
      tmp[1]   <= req.a01;
      tmp[2]   <= req.a10;
      tmp[3]   <= req.a11;
      n        <= mag[E-1:0] - E'(1);
      odd_done <= 1'b0;
      inv      <= 1'b0;
      sat      <= 1'b0;
      sing     <= 1'b0;
    end
    if (state == m2pow_pkg::ST_DET || state == m2pow_pkg::ST_MUL) begin
      if (phase == 2'd1) begin
        acc <= prod;
      end
      if (phase == 2'd2) begin
        if (state == m2pow_pkg::ST_DET) begin
          det <= sum;
        end else begin
          z[elem] <= clamped;
          sat     <= sat | ovp | ovn;
        end
      end
    end
    if (state == m2pow_pkg::ST_CHK) begin
      sing <= is_sing;
      inv  <= 1'b1;
    end
    if (state == m2pow_pkg::ST_DIV && div_stat.done) begin
      z[elem] <= div_quo;
      sat     <= sat | div_stat.sat;
    end
    if (state == m2pow_pkg::ST_STEP) begin
      sq <= !(n[0] && !odd_done);
    end
    if (state == m2pow_pkg::ST_COPY) begin
      if (inv) begin
        res <= z;
        tmp <= z;
        inv <= 1'b0;
      end else if (sq) begin
        tmp      <= z;
        n        <= n >> 1;
        odd_done <= 1'b0;
      end else begin
        res      <= z;
        odd_done <= 1'b1;
      end
    end
    if (load_rsp) begin
      rsp.r00       <= res[0];
      rsp.r01       <= res[1];
      rsp.r10       <= res[2];
      rsp.r11       <= res[3];
      rsp.singular  <= sing;
      rsp.saturated <= sat;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/m2pow_chk.sv
`default_nettype none
`include "assert_macros.svh"
module m2pow_chk (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            req_valid,
  input wire logic            req_stall,
  input wire logic            rsp_valid,
  input wire logic            rsp_stall,
  input wire m2pow_pkg::rsp_t rsp
);

  `ASSERT_CLK(a_rsp_hold, clk, rst, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "response dropped or changed while stalled")
  `ASSERT_CLK(a_busy_after_req, clk, rst, req_valid && !req_stall |=> req_stall, "block took a request without going busy")
  `ASSERT_CLK(a_sing_no_sat, clk, rst, rsp_valid && rsp.singular |-> !rsp.saturated, "singular response also flagged saturated")
  `ASSERT_CLK(a_rsp_from_busy, clk, rst, $rose(rsp_valid) |-> $past(req_stall), "response appeared without a request in flight")
  `ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !rsp_valid, "response valid right after reset")

endmodule

bind matrix2x2_signed_power_core m2pow_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_stall(req_stall),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp      (rsp)
);
`default_nettype wire
